// File: sv/pvp_pkg.sv
// Shared types, widths and constants for the priority voice player.
package pvp_pkg;

  // Fixed field widths
  localparam int KIND_W     = 4;
  localparam int REQ_BITS   = 14;
  localparam int FIRST_W    = 24;
  localparam int LEN_W      = 24;
  localparam int INDEX_W    = 25;
  localparam int PRIO_W     = 3;
  localparam int TIME_W     = 32;
  localparam int HOLD_W     = 24;
  localparam int RAMP_W     = 24;
  localparam int PTAB_W     = 42;
  localparam int CFG_DATA_W = 42;
  localparam int CFG_IDX_W  = 2;
  localparam int PRIO_LEVELS = 8;

  // Parameter defaults
  localparam int KINDS_DEFAULT         = 14;
  localparam int POSITION_BITS_DEFAULT = 24;

  // Register reset values
  localparam logic [PTAB_W-1:0] PTAB_RESET  = 42'd2491511803904;
  localparam logic [HOLD_W-1:0] HOLD_RESET  = 24'd400000;
  localparam logic [RAMP_W-1:0] RAMP_RESET  = 24'd0;
  localparam logic [KIND_W-1:0] KCOUNT_RESET = 4'd14;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_MUTE    = 2'd2,
    MODE_LOAD    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIORITY_TABLE = 2'd0,
    REG_HOLD_TIME_US   = 2'd1,
    REG_RAMP_LENGTH    = 2'd2,
    REG_KIND_COUNT     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    mode_t               mode;
    logic [REQ_BITS-1:0] request_bits;
    logic [TIME_W-1:0]   now_us;
    logic                mute_value;
    logic [KIND_W-1:0]   entry_kind;
    logic [FIRST_W-1:0]  entry_first;
    logic [LEN_W-1:0]    entry_length;
  } item_t;

  typedef struct packed {
    logic               sample_valid;
    logic [INDEX_W-1:0] sample_index;
    logic               started;
    logic [KIND_W-1:0]  started_kind;
    logic               retrigger;
    logic               playing;
    logic               stopped;
  } result_t;

endpackage

// File: sv/priority_voice_player.sv
// Priority voice player: one sound voice arbitrated by per-kind priorities.
// Throughput is one transaction per clock while the result channel does not
// stall; every transaction yields exactly one result, which is held first in
// the input register, loaded at the accepting edge, then in the result register.
// A stalled result holds the input register, which then stalls the item channel.
// The single combinational pass between them holds the
// priority select over the request mask, the hold-time compare and the
// position compare, and it updates the voice state in the same cycle, so
// a following transaction always sees the state left by the one before it.
// The per-kind first/length table powers up undefined; load every kind that
// a request may select before requesting it.
module priority_voice_player
  import pvp_pkg::*;
#(
  parameter int KINDS         = KINDS_DEFAULT,
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  // Only kinds below KINDS and below the request mask width are ever used
  localparam int ROWS   = (KINDS < REQ_BITS) ? KINDS : REQ_BITS;
  localparam int KIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W  = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
  localparam int SUM_W  = CMP_W + 1;
  localparam logic [KIND_W-1:0] ROWS_K = KIND_W'(ROWS);

  // Configuration registers
  logic [PTAB_W-1:0] priority_table;
  logic [HOLD_W-1:0] hold_time_us;
  logic [RAMP_W-1:0] ramp_length;
  logic [KIND_W-1:0] kind_count;

  // Voice state
  logic                     voice_busy, voice_busy_next;
  logic [KIND_W-1:0]        current_kind, current_kind_next;
  logic [POSITION_BITS-1:0] play_position, play_position_next;
  logic [PRIO_W-1:0]        current_priority, current_priority_next;
  logic [TIME_W-1:0]        start_time, start_time_next;
  logic                     mute_flag, mute_flag_next;
  // copy of the table entry of the current kind
  logic [FIRST_W-1:0]       cur_first, cur_first_next;
  logic [LEN_W-1:0]         cur_len, cur_len_next;

  logic [FIRST_W-1:0] first_table  [ROWS];
  logic [LEN_W-1:0]   length_table [ROWS];
  logic               table_we;

  // Input and result registers
  logic    in_full;
  item_t   in_q;
  logic    advance;
  logic    accept;
  result_t res_next;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      priority_table <= PTAB_RESET;
      hold_time_us   <= HOLD_RESET;
      ramp_length    <= RAMP_RESET;
      kind_count     <= KCOUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRIORITY_TABLE: priority_table <= cfg_data;
        REG_HOLD_TIME_US:   hold_time_us   <= cfg_data[HOLD_W-1:0];
        REG_RAMP_LENGTH:    ramp_length    <= cfg_data[RAMP_W-1:0];
        REG_KIND_COUNT:     kind_count     <= cfg_data[KIND_W-1:0];
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
  end

  // Priority select: eligible kinds, per-level match, highest level, lowest index
  logic [REQ_BITS-1:0]                  elig;
  logic [PRIO_LEVELS-1:0][REQ_BITS-1:0] lvl_mask;
  logic [PRIO_LEVELS-1:0]               lvl_any;
  logic [PRIO_W-1:0]                    best_prio;
  logic [REQ_BITS-1:0]                  sel, sel_low;
  logic [KIND_W-1:0]                    best_kind;
  logic                                 has_best;

  always_comb begin
    for (int k = 0; k < REQ_BITS; k++) begin
      elig[k] = (k < ROWS) && in_q.request_bits[k] && (KIND_W'(k) < kind_count);
    end
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      for (int k = 0; k < REQ_BITS; k++) begin
        lvl_mask[p][k] = (priority_table[3*k +: PRIO_W] == PRIO_W'(p));
      end
      lvl_any[p] = |(elig & lvl_mask[p]);
    end
    best_prio = '0;
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      if (lvl_any[p]) begin
        best_prio = PRIO_W'(p);
      end
    end
    sel     = elig & lvl_mask[best_prio];
    sel_low = sel & (~sel + REQ_BITS'(1));
    best_kind = '0;
    for (int k = 0; k < REQ_BITS; k++) begin
      if (sel_low[k]) begin
        best_kind = best_kind | KIND_W'(k);
      end
    end
    has_best = |elig;
  end

  // Table entry of the winning kind
  logic [FIRST_W-1:0] best_first;
  logic [LEN_W-1:0]   best_len;
  assign best_first = first_table[best_kind[KIDX_W-1:0]];
  assign best_len   = length_table[best_kind[KIDX_W-1:0]];

  // Per-item work
  logic [TIME_W-1:0]        elapsed;
  logic                     held;
  logic [RAMP_W-1:0]        skip;
  logic [CMP_W-1:0]         pos_ext, len_ext, pos_inc_ext;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [SUM_W-1:0]         idx_sum;

  always_comb begin
    voice_busy_next       = voice_busy;
    current_kind_next     = current_kind;
    play_position_next    = play_position;
    current_priority_next = current_priority;
    start_time_next       = start_time;
    mute_flag_next        = mute_flag;
    cur_first_next        = cur_first;
    cur_len_next          = cur_len;
    table_we              = 1'b0;
    res_next              = '0;

    elapsed     = in_q.now_us - start_time;
    held        = voice_busy && (best_prio < current_priority) &&
                  (elapsed < TIME_W'(hold_time_us));
    skip        = voice_busy ? ramp_length : '0;
    if (skip >= best_len) begin
      skip = '0;
    end
    pos_ext     = CMP_W'(play_position);
    len_ext     = CMP_W'(cur_len);
    pos_inc     = play_position + POSITION_BITS'(1);
    pos_inc_ext = CMP_W'(pos_inc);
    idx_sum     = SUM_W'(cur_first) + SUM_W'(play_position);

    unique case (in_q.mode)
      MODE_REQUEST: begin
        if (!mute_flag && has_best && !held) begin
          current_kind_next     = best_kind;
          play_position_next    = POSITION_BITS'(skip);
          voice_busy_next       = (best_len != '0);
          current_priority_next = best_prio;
          start_time_next       = in_q.now_us;
          cur_first_next        = best_first;
          cur_len_next          = best_len;
          res_next.started      = 1'b1;
          res_next.started_kind = best_kind;
          res_next.retrigger    = voice_busy;
        end
      end
      MODE_TICK: begin
        if (voice_busy) begin
          if (pos_ext >= len_ext) begin
            voice_busy_next = 1'b0;
          end else begin
            res_next.sample_valid = 1'b1;
            res_next.sample_index = idx_sum[INDEX_W-1:0];
            play_position_next    = pos_inc;
            if (pos_inc_ext >= len_ext) begin
              voice_busy_next = 1'b0;
            end
          end
        end
      end
      MODE_MUTE: begin
        if (in_q.mute_value != mute_flag) begin
          mute_flag_next = in_q.mute_value;
          if (in_q.mute_value && voice_busy) begin
            voice_busy_next  = 1'b0;
            res_next.stopped = 1'b1;
          end
        end
      end
      MODE_LOAD: begin
        if (in_q.entry_kind < ROWS_K) begin
          table_we = 1'b1;
          // keep the copy of the playing kind's entry in step
          if (in_q.entry_kind == current_kind) begin
            cur_first_next = in_q.entry_first;
            cur_len_next   = in_q.entry_length;
          end
        end
      end
    endcase

    res_next.playing = voice_busy_next;
  end

  // State update, one transaction per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_busy       <= 1'b0;
      current_kind     <= '0;
      play_position    <= '0;
      current_priority <= '0;
      start_time       <= '0;
      mute_flag        <= 1'b0;
    end else if (advance) begin
      voice_busy       <= voice_busy_next;
      current_kind     <= current_kind_next;
      play_position    <= play_position_next;
      current_priority <= current_priority_next;
      start_time       <= start_time_next;
      mute_flag        <= mute_flag_next;
    end
  end

  // Entry copy and table storage
  always_ff @(posedge clk) begin
    if (advance) begin
      cur_first <= cur_first_next;
      cur_len   <= cur_len_next;
      if (table_we) begin
        first_table[in_q.entry_kind[KIDX_W-1:0]]  <= in_q.entry_first;
        length_table[in_q.entry_kind[KIDX_W-1:0]] <= in_q.entry_length;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  // Checks
  a_mute_idle: assert property (@(posedge clk) disable iff (rst)
    mute_flag |-> !voice_busy)
    else $error("voice busy while muted");

  a_retrig_started: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.retrigger |-> result.started)
    else $error("retrigger without start");

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stopped |-> !result.playing && !result.sample_valid)
    else $error("stopped result still reports playback");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.started |=> current_kind < ROWS_K)
    else $error("started kind outside the table");

endmodule

// File: verif/priority_voice_player_test.sv
// Self-checking testbench for the priority voice player: predicts every result and compares it.
module priority_voice_player_test;
  import pvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_TOTAL    = KINDS_DEFAULT;
  localparam int POS_W         = POSITION_BITS_DEFAULT;
  localparam int PHASE_ITEMS   = 112;
  localparam int SETTLE_CYCLES = 6;
  localparam int END_CYCLES    = 10;
  localparam int QUIET_LIMIT   = 2000;

  // Voice predictor plus the queue of results it has worked out
  class voice_scoreboard;
    logic [PTAB_W-1:0] prio_table;
    logic [HOLD_W-1:0] hold_us;
    logic [RAMP_W-1:0] ramp_len;
    logic [KIND_W-1:0] kind_count;

    logic               busy;
    logic [KIND_W-1:0]  cur_kind;
    logic [POS_W-1:0]   position;
    logic [PRIO_W-1:0]  cur_prio;
    logic [TIME_W-1:0]  start_us;
    logic               muted;
    logic [FIRST_W-1:0] first_tab[KIND_TOTAL];
    logic [LEN_W-1:0]   len_tab[KIND_TOTAL];

    result_t expected_results[$];
    int      errors;

    function new();
      prio_table = PTAB_RESET;
      hold_us    = HOLD_RESET;
      ramp_len   = RAMP_RESET;
      kind_count = KCOUNT_RESET;
      busy       = 1'b0;
      cur_kind   = '0;
      position   = '0;
      cur_prio   = '0;
      start_us   = '0;
      muted      = 1'b0;
      errors     = 0;
      foreach (first_tab[k]) begin
        first_tab[k] = '0;
        len_tab[k]   = '0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PRIORITY_TABLE: prio_table = d[PTAB_W-1:0];
        REG_HOLD_TIME_US:   hold_us    = d[HOLD_W-1:0];
        REG_RAMP_LENGTH:    ramp_len   = d[RAMP_W-1:0];
        REG_KIND_COUNT:     kind_count = d[KIND_W-1:0];
      endcase
    endfunction

    // One transaction through the voice: updates state, returns its result
    function result_t predict_voice(item_t it);
      result_t            r;
      logic               found;
      int                 best;
      int                 k;
      logic [PRIO_W-1:0]  p;
      logic [PRIO_W-1:0]  bestp;
      logic [TIME_W-1:0]  elapsed;
      logic [LEN_W-1:0]   len;
      logic [RAMP_W-1:0]  skip;
      r = '0;
      case (it.mode)
        MODE_REQUEST: begin
          if (!muted && it.request_bits != '0) begin
            found = 1'b0;
            best  = 0;
            bestp = '0;
            // highest priority wins, ties go to the lowest kind
            for (k = 0; k < KIND_TOTAL && k < kind_count && k < REQ_BITS; k++) begin
              p = prio_table[PRIO_W*k +: PRIO_W];
              if (it.request_bits[k] && (!found || p > bestp)) begin
                found = 1'b1;
                best  = k;
                bestp = p;
              end
            end
            if (found) begin
              elapsed = it.now_us - start_us;
              // lower priority stays out while the current sound is in its hold time
              if (!(busy && bestp < cur_prio && elapsed < hold_us)) begin
                len  = len_tab[best];
                skip = busy ? ramp_len : '0;
                if (skip >= len) skip = '0;
                r.retrigger    = busy;
                r.started      = 1'b1;
                r.started_kind = KIND_W'(best);
                cur_kind       = KIND_W'(best);
                position       = POS_W'(skip);
                busy           = (len != '0);
                cur_prio       = bestp;
                start_us       = it.now_us;
              end
            end
          end
        end
        MODE_TICK: begin
          if (busy) begin
            len = len_tab[cur_kind];
            if (position >= len) begin
              // table was reloaded shorter than the position
              busy = 1'b0;
            end else begin
              r.sample_valid = 1'b1;
              r.sample_index = INDEX_W'(first_tab[cur_kind]) + INDEX_W'(position);
              position       = position + 1'b1;
              if (position >= len) busy = 1'b0;
            end
          end
        end
        MODE_MUTE: begin
          if (it.mute_value != muted) begin
            muted = it.mute_value;
            if (muted && busy) begin
              busy      = 1'b0;
              r.stopped = 1'b1;
            end
          end
        end
        MODE_LOAD: begin
          if (it.entry_kind < KIND_TOTAL) begin
            first_tab[it.entry_kind] = it.entry_first;
            len_tab[it.entry_kind]   = it.entry_length;
          end
        end
      endcase
      r.playing = busy;
      return r;
    endfunction

    function void note_item(item_t it);
      expected_results.push_back(predict_voice(it));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %0h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.sample_valid !== want.sample_valid)
        report_field("sample_valid", want.sample_valid, got.sample_valid);
      if (got.sample_index !== want.sample_index)
        report_field("sample_index", want.sample_index, got.sample_index);
      if (got.started !== want.started)
        report_field("started", want.started, got.started);
      if (got.started_kind !== want.started_kind)
        report_field("started_kind", want.started_kind, got.started_kind);
      if (got.retrigger !== want.retrigger)
        report_field("retrigger", want.retrigger, got.retrigger);
      if (got.playing !== want.playing)
        report_field("playing", want.playing, got.playing);
      if (got.stopped !== want.stopped)
        report_field("stopped", want.stopped, got.stopped);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item_data = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_data;

  voice_scoreboard sb = new();

  int                send_idle = 17;
  int                recv_idle = 48;
  int                step_max = 2;
  logic [TIME_W-1:0] clock_us = '0;

  priority_voice_player uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_data)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_data);
  end

  // Watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("priority_voice_player_test: done, errors");
    $finish;
  end

  // Send one transaction after a random gap, note it when accepted
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  // Stop sending until every expected result is back, then let the pipe settle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic send_op(input mode_t m, input logic [REQ_BITS-1:0] bits, input logic mute,
                         input logic [KIND_W-1:0] kind, input logic [FIRST_W-1:0] first,
                         input logic [LEN_W-1:0] len);
    item_t it;
    it              = '0;
    clock_us        = clock_us + 997;
    it.mode         = m;
    it.request_bits = bits;
    it.now_us       = clock_us;
    it.mute_value   = mute;
    it.entry_kind   = kind;
    it.entry_first  = first;
    it.entry_length = len;
    send_item(it);
  endtask

  // Mostly well-formed requests and tick runs, some raw noise
  function automatic item_t random_item();
    logic [127:0] raw;
    item_t        it;
    int           pick;
    int           nbits;
    raw      = {$urandom(), $urandom(), $urandom(), $urandom()};
    it       = raw[$bits(item_t)-1:0];
    clock_us = clock_us + $urandom_range(0, step_max);
    pick     = $urandom_range(0, 99);
    if (pick < 10) return it;
    it.now_us = clock_us;
    if (pick < 38) begin
      it.mode = MODE_REQUEST;
      if ($urandom_range(0, 6) == 0) begin
        it.request_bits = raw[127:114];
      end else begin
        it.request_bits = '0;
        nbits = $urandom_range(1, 3);
        repeat (nbits) it.request_bits[$urandom_range(0, REQ_BITS-1)] = 1'b1;
      end
    end else if (pick < 85) begin
      it.mode = MODE_TICK;
    end else if (pick < 92) begin
      it.mode       = MODE_MUTE;
      it.mute_value = ($urandom_range(0, 3) == 0);
    end else begin
      it.mode       = MODE_LOAD;
      it.entry_kind = KIND_W'($urandom_range(0, 15));
      // mostly short sounds so they run out; now and then a huge one
      if ($urandom_range(0, 9) != 0) it.entry_length = LEN_W'($urandom_range(0, 24));
    end
    return it;
  endfunction

  // Register settings per phase, extremes included
  task automatic apply_setting(input int n);
    logic [63:0]       rnd;
    logic [PTAB_W-1:0] ptab;
    logic [HOLD_W-1:0] hold;
    logic [RAMP_W-1:0] ramp;
    logic [KIND_W-1:0] kc;
    rnd      = {$urandom(), $urandom()};
    ptab     = rnd[PTAB_W-1:0];
    clock_us = $urandom();
    case (n)
      0: begin hold = HOLD_RESET; ramp = '0; kc = KCOUNT_RESET; end
      1: begin ptab = '1; hold = '1; ramp = '1; kc = '1; end
      2: begin ptab = '0; hold = '0; ramp = '0; kc = 4'd1; end
      3: begin
        hold = HOLD_W'($urandom_range(20, 3000));
        ramp = RAMP_W'($urandom_range(0, 6));
        kc   = KIND_W'($urandom_range(1, 14));
      end
      4: begin
        hold = HOLD_W'($urandom_range(0, 5000));
        ramp = RAMP_W'($urandom_range(0, 30));
        kc   = KIND_W'($urandom_range(0, 15));
      end
      default: begin
        hold     = HOLD_W'($urandom_range(100, 1000));
        ramp     = RAMP_W'($urandom_range(0, 3));
        kc       = 4'd14;
        clock_us = 32'hFFFF_FF00;  // run across the time wrap
      end
    endcase
    step_max = int'(hold) / 16 + 2;
    write_reg(REG_PRIORITY_TABLE, CFG_DATA_W'(ptab));
    write_reg(REG_HOLD_TIME_US, CFG_DATA_W'(hold));
    write_reg(REG_RAMP_LENGTH, CFG_DATA_W'(ramp));
    write_reg(REG_KIND_COUNT, CFG_DATA_W'(kc));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int count);
    apply_setting(n);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
        // second half of this phase runs with no eligible kind
        if (n == 2) begin
          write_reg(REG_KIND_COUNT, '0);
          cfg_write <= 1'b0;
          @(posedge clk);
        end
      end
      send_item(random_item());
    end
    drain();
  endtask

  // Directed: fill the whole table, then walk the special cases
  task automatic run_directed();
    write_reg(REG_PRIORITY_TABLE, CFG_DATA_W'(PTAB_RESET));
    write_reg(REG_HOLD_TIME_US, '0);
    write_reg(REG_RAMP_LENGTH, CFG_DATA_W'(2));
    write_reg(REG_KIND_COUNT, CFG_DATA_W'(KCOUNT_RESET));
    cfg_write <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < KIND_TOTAL; k++) begin
      if (k == 0)
        send_op(MODE_LOAD, '0, 1'b0, '0, '1, '1);
      else
        send_op(MODE_LOAD, '0, 1'b0, KIND_W'(k), FIRST_W'(k * 32'h0012_3457),
                LEN_W'((k == 1) ? 0 : k % 4 + 2));
    end
    send_op(MODE_LOAD, '0, 1'b0, 4'd15, '1, LEN_W'(5));    // kind out of range
    send_op(MODE_REQUEST, '0, 1'b0, '0, '0, '0);           // empty mask
    send_op(MODE_REQUEST, 14'h0002, 1'b0, '0, '0, '0);     // zero-length sound
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);              // tick while idle
    send_op(MODE_REQUEST, 14'h0020, 1'b0, '0, '0, '0);
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);
    send_op(MODE_LOAD, '0, 1'b0, 4'd5, FIRST_W'(5 * 32'h0012_3457), LEN_W'(1));
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);              // position reaches new length
    send_op(MODE_REQUEST, 14'h2000, 1'b0, '0, '0, '0);
    send_op(MODE_REQUEST, 14'h2000, 1'b0, '0, '0, '0);     // retrigger, ramp skipped
    send_op(MODE_REQUEST, 14'h1000, 1'b0, '0, '0, '0);     // ramp not shorter than sound
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);
    send_op(MODE_REQUEST, '1, 1'b0, '0, '0, '0);
    send_op(MODE_MUTE, '0, 1'b1, '0, '0, '0);              // cuts off the sound
    send_op(MODE_REQUEST, 14'h0008, 1'b0, '0, '0, '0);     // ignored while muted
    send_op(MODE_MUTE, '0, 1'b1, '0, '0, '0);              // same value
    send_op(MODE_MUTE, '0, 1'b0, '0, '0, '0);
    send_op(MODE_REQUEST, 14'h0001, 1'b0, '0, '0, '0);
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);
    send_op(MODE_TICK, '0, 1'b0, '0, '0, '0);              // index carries into bit 24
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int n = 0; n < 6; n++) begin
      if (n == 2) begin
        send_idle = 48;
        recv_idle = 17;
      end
      if (n == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_phase(n, PHASE_ITEMS);
    end
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("priority_voice_player_test: done, clean");
    else
      $display("priority_voice_player_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/pvp_pkg.sv
sv/priority_voice_player.sv
verif/priority_voice_player_test.sv
